// ----- design/indexed_list_engine_assert.svh -----
// ----------------------------------------------------------------------------
// indexed_list_engine assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Request and status codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_REMOVE = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ISHIFT,
    S_PUT,
    S_RSHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [COUNT_W-1:0] item_count;
  } result_t;

endpackage

`default_nettype wire

// ----- design/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded positional list: read, overwrite, append, insert and remove requests.
// ----------------------------------------------------------------------------
// accept to out_valid: overwrite, append and errors go straight to finish;
//   read adds S_READ, insert S_ISHIFT and S_PUT, remove S_RSHIFT if not last
// one request at a time; the next is taken once the result enters the output
//   register; shifts move one entry per cycle through the single write port
// reset clears the count and handshake state; storage is not cleared
`default_nettype none

module indexed_list_engine #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ITEM_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [9:0]  position,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [10:0] item_count
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic                  res_valid;
  logic                  res_ready;
  ile_pkg::result_t      res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;

  ile_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ITEM_WIDTH  (ITEM_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .position   (position),
    .item_value (item_value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ile_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register, free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_value <= res.read_value;
      status     <= res.status;
      item_count <= res.item_count;
    end
  end

endmodule

`default_nettype wire

// ----- design/ile_ram.sv -----
// ----------------------------------------------------------------------------
// ile_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ile_seq.sv -----
// ----------------------------------------------------------------------------
// ile_seq
// Request sequencer: checks, item count and the read/write-back shift passes.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_seq #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ITEM_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     req_type,
  input  logic [ile_pkg::POS_W-1:0]      position,
  input  logic [ile_pkg::VALUE_W-1:0]    item_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ile_pkg::result_t               res,
  output logic                           mem_we,
  output logic [$clog2(MAX_ENTRIES)-1:0] mem_waddr,
  output logic [ITEM_WIDTH-1:0]          mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(MAX_ENTRIES)-1:0] mem_raddr,
  input  logic [ITEM_WIDTH-1:0]          mem_rdata
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

  ile_pkg::state_t             state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [AW-1:0]               widx, widx_next;
  logic [AW-1:0]               pos_r, pos_next;
  logic [ITEM_WIDTH-1:0]       val_r, val_next;
  logic [ile_pkg::VALUE_W-1:0] res_value, res_value_next;
  ile_pkg::status_t            res_status, res_status_next;

  logic          pos_bad;
  logic          full;
  logic          remove_last;
  logic [AW-1:0] addr_pos;

  // compare at the wider of the two widths so no position bits are lost
  assign pos_bad     = CMPW'(position) >= CMPW'(count);
  assign full        = count == CW'(MAX_ENTRIES);
  assign remove_last = (CMPW'(position) + CMPW'(1)) == CMPW'(count);
  assign addr_pos    = AW'(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    widx       <= widx_next;
    pos_r      <= pos_next;
    val_r      <= val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    widx_next       = widx;
    pos_next        = pos_r;
    val_next        = val_r;
    res_value_next  = res_value;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = widx;
    mem_wdata       = mem_rdata;
    mem_re          = 1'b0;
    mem_raddr       = widx;
    in_ready        = state == ile_pkg::S_IDLE;
    res_valid       = state == ile_pkg::S_FINISH;

    case (state)
      ile_pkg::S_IDLE: begin
        if (in_valid) begin
          pos_next        = addr_pos;
          val_next        = ITEM_WIDTH'(item_value);
          res_value_next  = '0;
          res_status_next = ile_pkg::ST_OK;
          state_next      = ile_pkg::S_FINISH;
          case (ile_pkg::req_t'(req_type))
            ile_pkg::REQ_READ: begin
              if (pos_bad) begin
                res_status_next = ile_pkg::ST_BADPOS;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = addr_pos;
                state_next = ile_pkg::S_READ;
              end
            end
            ile_pkg::REQ_WRITE: begin
              if (pos_bad) begin
                res_status_next = ile_pkg::ST_BADPOS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = addr_pos;
                mem_wdata = ITEM_WIDTH'(item_value);
              end
            end
            ile_pkg::REQ_APPEND: begin
              if (full) begin
                res_status_next = ile_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(count);
                mem_wdata  = ITEM_WIDTH'(item_value);
                count_next = count + CW'(1);
              end
            end
            ile_pkg::REQ_INSERT: begin
              if (pos_bad) begin
                res_status_next = ile_pkg::ST_BADPOS;
              end else if (full) begin
                res_status_next = ile_pkg::ST_FULL;
              end else begin
                // walk from the tail down, moving each item up one place
                mem_re     = 1'b1;
                mem_raddr  = AW'(count - CW'(1));
                widx_next  = AW'(count);
                state_next = ile_pkg::S_ISHIFT;
              end
            end
            ile_pkg::REQ_REMOVE: begin
              if (pos_bad) begin
                res_status_next = ile_pkg::ST_BADPOS;
              end else if (remove_last) begin
                count_next = count - CW'(1);
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = addr_pos + AW'(1);
                widx_next  = addr_pos;
                state_next = ile_pkg::S_RSHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      ile_pkg::S_READ: begin
        res_value_next = ile_pkg::VALUE_W'(mem_rdata);
        state_next     = ile_pkg::S_FINISH;
      end
      ile_pkg::S_ISHIFT: begin
        // write lands two entries above the next read, no overlap
        mem_we    = 1'b1;
        mem_waddr = widx;
        mem_wdata = mem_rdata;
        if ((widx - AW'(1)) == pos_r) begin
          state_next = ile_pkg::S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = widx - AW'(2);
          widx_next = widx - AW'(1);
        end
      end
      ile_pkg::S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_r;
        mem_wdata  = val_r;
        count_next = count + CW'(1);
        state_next = ile_pkg::S_FINISH;
      end
      ile_pkg::S_RSHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = widx;
        mem_wdata = mem_rdata;
        if ((CW'(widx) + CW'(2)) == count) begin
          count_next = count - CW'(1);
          state_next = ile_pkg::S_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = widx + AW'(2);
          widx_next = widx + AW'(1);
        end
      end
      ile_pkg::S_FINISH: begin
        if (res_ready) begin
          state_next = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

  assign res.read_value = res_value;
  assign res.status     = res_status;
  assign res.item_count = ile_pkg::COUNT_W'(count);

endmodule

`default_nettype wire

// ----- design/ile_checker.sv -----
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_engine_assert.svh"

module ile_checker #(
  parameter int MAX_ENTRIES = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_value,
  input logic [1:0]  status,
  input logic [10:0] item_count
);

  `ILE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(status) && $stable(item_count), "result changed while stalled")

  `ILE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while another is in work")

  `ILE_ASSERT_NOW(a_error_no_data, out_valid && (status != ile_pkg::ST_OK), read_value == 32'd0, "failed request returned data")

  `ILE_ASSERT_NOW(a_count_bound, out_valid, (MAX_ENTRIES > 2047) || (item_count <= 11'(MAX_ENTRIES)), "item count above capacity")

  `ILE_ASSERT_NOW(a_full_count, out_valid && (status == ile_pkg::ST_FULL), item_count == 11'(MAX_ENTRIES), "full status with room left")

endmodule

bind indexed_list_engine ile_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_ile_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_value (read_value),
  .status     (status),
  .item_count (item_count)
);

`default_nettype wire
